FILE: rtl/modbus_rtu_request_framer_top_assert.svh
// Assertion macros shared by the framer's checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MODBUS_RTU_REQUEST_FRAMER_TOP_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MBRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define MBRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mbrf_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the request framer.
// Used by every module of the framer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mbrf_pkg;

    localparam int MAX_WORDS   = 123;
    localparam int WORDS_W     = 7;
    localparam int JOB_BYTES   = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FUNC_WRITE_MULTI  = 8'h10;

    typedef enum logic [1:0] {
        CMD_READ_HOLDING = 2'd0,
        CMD_WRITE_SINGLE = 2'd1,
        CMD_WRITE_MULTI  = 2'd2,
        CMD_WRITE_DATA   = 2'd3
    } cmd_t;

    // One queued job: up to seven plain bytes, then optionally the two CRC bytes.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                n_data;
        logic                      tail;
        logic                      restart;
        logic                      err;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/modbus_rtu_request_framer_top.sv
// Modbus RTU request framer: commands in, request frame bytes with CRC-16 out.
// Usage:
//   Input channel s_*: s_tuser is the command (0 read holding, 1 write single,
//   2 write multiple header, 3 write multiple data word); s_tdata carries the
//   slave address, register address and count or value.
//   Output channel m_*: one frame byte per item, m_tlast on the CRC high byte
//   that closes a frame, m_tuser set on the single item of a rejected command.
//   Path: when the block is empty, an accepted item passes through the job
//   queue and the output register before its first byte can be taken.
//   Throughput: one output byte per cycle unless stalled. An item gives
//   8 bytes for reads and single writes, 7 for a multi-write header, 2 or 4
//   for a data word, 1 for a rejected item. The output serializer sets
//   this rate; a four-entry job queue lets new items in while it works.
//   Reset clears the queue, the open-frame tracking and the running CRC.
//   When the receiver stalls, the output byte holds, the queue fills, and then
//   s_tready drops until room frees up.
// Depends on mbrf_pkg, mbrf_front, mbrf_queue and mbrf_back.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_request_framer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // slave_address, register_address, count_or_value
    input  wire logic [1:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // frame_byte
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // error
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    mbrf_pkg::job_t push_job;
    mbrf_pkg::job_t head_job;

    mbrf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    mbrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_job),
        .not_empty (q_not_empty)
    );

    mbrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (q_not_empty),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/mbrf_front.sv
// Front end of the framer: accepts commands, tracks the open multi-write frame
// and turns each item into a byte job for the queue. Depends on mbrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,
    input  wire logic [1:0]    s_tuser,
    input  wire logic          q_full,
    output logic               q_push,
    output mbrf_pkg::job_t     q_job
);

    mbrf_pkg::cmd_t                    cmd;
    logic [7:0]                        slave;
    logic [15:0]                       reg_addr;
    logic [15:0]                       val;
    logic                              count_bad;
    logic [7:0]                        func;
    logic [mbrf_pkg::WORDS_W-1:0]      words_dec;
    logic [mbrf_pkg::WORDS_W-1:0]      words_left_reg;
    logic [mbrf_pkg::WORDS_W-1:0]      words_left_next;
    logic                              frame_open_reg;
    logic                              frame_open_next;
    mbrf_pkg::job_t                    job;

    assign cmd      = mbrf_pkg::cmd_t'(s_tuser);
    assign slave    = s_tdata[7:0];
    assign reg_addr = s_tdata[23:8];
    assign val      = s_tdata[39:24];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_job    = job;

    assign count_bad = (val == 16'd0) || (val > 16'(mbrf_pkg::MAX_WORDS));
    assign words_dec = words_left_reg - 1'b1;

    always_comb
    begin
        unique case (cmd)
            mbrf_pkg::CMD_READ_HOLDING: func = mbrf_pkg::FUNC_READ_HOLDING;
            mbrf_pkg::CMD_WRITE_SINGLE: func = mbrf_pkg::FUNC_WRITE_SINGLE;
            default:                    func = mbrf_pkg::FUNC_WRITE_MULTI;
        endcase
    end

    always_comb
    begin
        job             = '0;
        words_left_next = words_left_reg;
        frame_open_next = frame_open_reg;
        if (cmd == mbrf_pkg::CMD_WRITE_DATA)
        begin
            if (!frame_open_reg)
            begin
                job.n_data = 3'd1;
                job.err    = 1'b1;
            end
            else
            begin
                job.bytes[0]    = val[15:8];
                job.bytes[1]    = val[7:0];
                job.n_data      = 3'd2;
                words_left_next = words_dec;
                if (words_dec == '0)
                begin
                    job.tail        = 1'b1;
                    frame_open_next = 1'b0;
                end
            end
        end
        else if (cmd == mbrf_pkg::CMD_WRITE_MULTI && count_bad)
        begin
            // A rejected count leaves any open frame untouched.
            job.n_data = 3'd1;
            job.err    = 1'b1;
        end
        else
        begin
            job.restart  = 1'b1;
            job.bytes[0] = slave;
            job.bytes[1] = func;
            job.bytes[2] = reg_addr[15:8];
            job.bytes[3] = reg_addr[7:0];
            job.bytes[4] = val[15:8];
            job.bytes[5] = val[7:0];
            if (cmd == mbrf_pkg::CMD_WRITE_MULTI)
            begin
                // Byte count is twice the word count; the count is at most 123.
                job.bytes[6]    = {val[6:0], 1'b0};
                job.n_data      = 3'd7;
                words_left_next = val[mbrf_pkg::WORDS_W-1:0];
                frame_open_next = 1'b1;
            end
            else
            begin
                job.n_data      = 3'd6;
                job.tail        = 1'b1;
                words_left_next = '0;
                frame_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_left_reg <= '0;
            frame_open_reg <= 1'b0;
        end
        else if (q_push)
        begin
            words_left_reg <= words_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mbrf_queue.sv
// Short job queue between the framer's front and back ends.
// Depends on mbrf_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module mbrf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mbrf_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output mbrf_pkg::job_t      head,
    output logic                not_empty
);

    mbrf_pkg::job_t                 mem_reg [mbrf_pkg::QUEUE_DEPTH];
    logic [mbrf_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mbrf_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mbrf_pkg::QCNT_W-1:0]    count_reg;
    logic [mbrf_pkg::QCNT_W-1:0]    count_next;
    logic                           do_pop;

    assign full      = (count_reg == mbrf_pkg::QCNT_W'(mbrf_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mbrf_back.sv
// Back end of the framer: walks the head job byte by byte, folds bytes into the
// running CRC and drives the registered output stream. Depends on mbrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mbrf_pkg::job_t job,
    input  wire logic           job_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [0:0]          m_tuser
);

    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_err_reg;

    logic        load;
    logic [15:0] crc_base;
    logic [15:0] crc_next;
    logic [7:0]  byte_next;
    logic        last_next;
    logic [3:0]  total;
    logic        final_byte;

    assign load = job_valid && (!out_valid_reg || m_tready);
    assign pop  = load && final_byte;

    assign total      = {1'b0, job.n_data} + (job.tail ? 4'd2 : 4'd0);
    assign final_byte = ({1'b0, idx_reg} + 4'd1) == total;

    // A new frame starts its CRC afresh, dropping any abandoned partial frame.
    assign crc_base = (job.restart && idx_reg == 3'd0) ? mbrf_pkg::CRC_INIT : crc_reg;

    always_comb
    begin
        byte_next = 8'h00;
        last_next = 1'b0;
        crc_next  = crc_base;
        if (idx_reg < job.n_data)
        begin
            byte_next = job.bytes[idx_reg];
            if (!job.err)
            begin
                crc_next = mbrf_pkg::crc_byte(crc_base, byte_next);
            end
        end
        else if (idx_reg == job.n_data)
        begin
            byte_next = crc_base[7:0];
        end
        else
        begin
            byte_next = crc_base[15:8];
            last_next = 1'b1;
            crc_next  = mbrf_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= mbrf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= final_byte ? 3'd0 : idx_reg + 3'd1;
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_next;
            out_last_reg <= last_next;
            out_err_reg  <= job.err;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

endmodule

`default_nettype wire

FILE: rtl/mbrf_checker.sv
// Port-level checker for the request framer's output stream, bound to the top.
// Depends on modbus_rtu_request_framer_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_request_framer_top_assert.svh"

module mbrf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [0:0] m_tuser
);

    logic out_take;

    assign out_take = m_tvalid && m_tready;

    `MBRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output item changed while stalled")

    // A rejected command gives a lone zero byte that never ends a frame.
    `MBRF_ASSERT_NOW(a_err_shape, m_tvalid && m_tuser[0], m_tdata == 8'h00 && !m_tlast, "error item carries data or frame end")

    // Every CRC tail follows at least one data byte, so frame ends never abut.
    `MBRF_ASSERT_NEXT(a_no_double_end, out_take && m_tlast, !(out_take && m_tlast), "two frame ends delivered back to back")

endmodule

bind modbus_rtu_request_framer_top mbrf_checker u_mbrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: bench/modbus_rtu_request_framer_checker.sv
`timescale 1ns / 1ps
// Checker for the Modbus RTU request framer: predicts frame bytes and CRC from accepted items
// and compares every accepted output item against them. Depends on mbrf_pkg for types.

module modbus_rtu_request_framer_checker
    import mbrf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // slave_address, register_address, count_or_value
    input  wire logic [1:0]  s_tuser,   // command
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // frame_byte
    input  wire logic        m_tlast,
    input  wire logic [0:0]  m_tuser,   // error
    output int               mismatches,
    output int               beats_due,
    output int               frames_closed,
    output int               rejects_seen
);

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
        logic       err;
    } frame_beat_t;

    frame_beat_t expected_beats[$];

    // Predictor state of the open multiple-register write.
    logic [15:0]        crc_acc;
    logic [WORDS_W-1:0] words_due;
    logic               multi_open;

    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        r = acc ^ {8'h00, octet};
        repeat (8)
        begin
            r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic push_beat(input logic [7:0] octet, input logic last, input logic err);
        frame_beat_t beat;
        beat.octet = octet;
        beat.last  = last;
        beat.err   = err;
        expected_beats.push_back(beat);
    endtask

    task automatic push_crc_octet(input logic [7:0] octet);
        crc_acc = crc16_fold(crc_acc, octet);
        push_beat(octet, 1'b0, 1'b0);
    endtask

    task automatic push_crc_tail();
        push_beat(crc_acc[7:0], 1'b0, 1'b0);
        push_beat(crc_acc[15:8], 1'b1, 1'b0);
        crc_acc = CRC_INIT;
    endtask

    task automatic predict_request(input cmd_t cmd, input logic [7:0] slave,
                                   input logic [15:0] reg_addr, input logic [15:0] value);
        logic [7:0] func_code;
        if (cmd == CMD_WRITE_DATA)
        begin
            if (!multi_open)
            begin
                push_beat(8'h00, 1'b0, 1'b1);
            end
            else
            begin
                push_crc_octet(value[15:8]);
                push_crc_octet(value[7:0]);
                words_due = words_due - 1'b1;
                if (words_due == '0)
                begin
                    push_crc_tail();
                    multi_open = 1'b0;
                end
            end
        end
        else if (cmd == CMD_WRITE_MULTI && (value == 16'd0 || value > MAX_WORDS))
        begin
            // A rejected word count leaves any open frame untouched.
            push_beat(8'h00, 1'b0, 1'b1);
        end
        else
        begin
            multi_open = 1'b0;
            words_due  = '0;
            crc_acc    = CRC_INIT;
            case (cmd)
                CMD_READ_HOLDING: func_code = FUNC_READ_HOLDING;
                CMD_WRITE_SINGLE: func_code = FUNC_WRITE_SINGLE;
                default:          func_code = FUNC_WRITE_MULTI;
            endcase
            push_crc_octet(slave);
            push_crc_octet(func_code);
            push_crc_octet(reg_addr[15:8]);
            push_crc_octet(reg_addr[7:0]);
            push_crc_octet(value[15:8]);
            push_crc_octet(value[7:0]);
            if (cmd == CMD_WRITE_MULTI)
            begin
                push_crc_octet({value[6:0], 1'b0});
                words_due  = value[WORDS_W-1:0];
                multi_open = 1'b1;
            end
            else
            begin
                push_crc_tail();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("mismatch at %0t ns: %s is %0h, predicted %0h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_beat_t want;
        if (!rst_n)
        begin
            expected_beats.delete();
            crc_acc       = CRC_INIT;
            words_due     = '0;
            multi_open    = 1'b0;
            mismatches    = 0;
            beats_due     = 0;
            frames_closed = 0;
            rejects_seen  = 0;
        end
        else
        begin
            // Outputs first: an item accepted at this edge cannot have a byte out yet.
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("unpredicted frame byte", {8'h00, m_tdata}, 16'h0000);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.octet)
                        report_mismatch("frame_byte", {8'h00, m_tdata}, {8'h00, want.octet});
                    if (m_tlast !== want.last)
                        report_mismatch("end_of_frame", {15'h0000, m_tlast}, {15'h0000, want.last});
                    if (m_tuser[0] !== want.err)
                        report_mismatch("error", {15'h0000, m_tuser[0]}, {15'h0000, want.err});
                    if (want.last)
                        frames_closed++;
                    if (want.err)
                        rejects_seen++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_request(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[23:8], s_tdata[39:24]);
            end
            beats_due = expected_beats.size();
        end
    end

endmodule

FILE: bench/tb_modbus_rtu_request_framer_top.sv
`timescale 1ns / 1ps
// Testbench top for the Modbus RTU request framer: drives request commands with random gaps
// and output stalls, and gives the verdict. Depends on mbrf_pkg and the framer checker.

module tb_modbus_rtu_request_framer_top;
    import mbrf_pkg::*;

    localparam int ITEM_TARGET = 470;
    localparam int CALM_ITEMS  = 60;
    localparam int CYCLE_LIMIT = 250000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // slave_address, register_address, count_or_value
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // frame_byte
    logic        m_tlast;
    logic [0:0]  m_tuser;   // error

    int mismatches;
    int beats_due;
    int frames_closed;
    int rejects_seen;
    int items_sent;
    int cycle_count;
    bit source_calm;
    bit sink_calm;

    modbus_rtu_request_framer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    modbus_rtu_request_framer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .beats_due     (beats_due),
        .frames_closed (frames_closed),
        .rejects_seen  (rejects_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[modbus_rtu_request_framer_top] ERROR");
        $finish;
    end

    // Receiver: random stall bursts until the calm stretch at the end.
    initial
    begin : sink
        int hold;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!sink_calm && $urandom_range(0, 6) == 0)
            begin
                hold = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] any_word();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [7:0] any_octet();
        return 8'($urandom_range(0, 8'hFF));
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_command(input cmd_t cmd, input logic [7:0] slave,
                                input logic [15:0] reg_addr, input logic [15:0] value);
        int gap;
        if (!source_calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, reg_addr, slave};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic push_data_words(input int count);
        repeat (count) push_command(CMD_WRITE_DATA, any_octet(), any_word(), any_word());
    endtask

    task automatic drain_frames();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (beats_due != 0);
    endtask

    initial
    begin : stimulus
        int choice;
        int words;
        int sent;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_READ_HOLDING;
        items_sent  = 0;
        source_calm = 1'b0;
        sink_calm   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Field extremes and the plain frames.
        push_command(CMD_READ_HOLDING, 8'h00, 16'h0000, 16'h0000);
        push_command(CMD_READ_HOLDING, 8'hFF, 16'hFFFF, 16'hFFFF);
        push_command(CMD_WRITE_SINGLE, 8'hA5, 16'h5A5A, 16'hA5A5);
        push_command(CMD_WRITE_SINGLE, 8'h5A, 16'hA5A5, 16'h5A5A);
        // A data word with no frame open, then word counts out of range.
        push_command(CMD_WRITE_DATA, 8'hFF, 16'hFFFF, 16'hFFFF);
        push_command(CMD_WRITE_MULTI, 8'h11, 16'h0100, 16'd0);
        push_command(CMD_WRITE_MULTI, 8'h11, 16'h0100, 16'(MAX_WORDS + 1));
        push_command(CMD_WRITE_MULTI, 8'h11, 16'h0100, 16'hFFFF);
        push_command(CMD_WRITE_MULTI, 8'h01, 16'h0010, 16'd1);
        push_command(CMD_WRITE_DATA, 8'h00, 16'h0000, 16'hFFFF);
        // A bad count in the middle of an open frame must not disturb it.
        push_command(CMD_WRITE_MULTI, 8'h02, 16'h1000, 16'd3);
        push_command(CMD_WRITE_DATA, 8'h00, 16'h0000, 16'h0000);
        push_command(CMD_WRITE_MULTI, 8'h02, 16'h1000, 16'd200);
        push_command(CMD_WRITE_DATA, 8'h00, 16'h0000, 16'h1234);
        push_command(CMD_WRITE_DATA, 8'h00, 16'h0000, 16'h8001);
        // A read abandons a partial frame, after which data words are strays.
        push_command(CMD_WRITE_MULTI, 8'h03, 16'h2000, 16'd2);
        push_command(CMD_WRITE_DATA, 8'h00, 16'h0000, 16'hABCD);
        push_command(CMD_READ_HOLDING, 8'h03, 16'h2000, 16'd10);
        push_command(CMD_WRITE_DATA, 8'h00, 16'h0000, 16'h5555);
        // A new header abandons the open frame too.
        push_command(CMD_WRITE_MULTI, 8'h04, 16'h3000, 16'd2);
        push_command(CMD_WRITE_MULTI, 8'h04, 16'h3002, 16'd1);
        push_command(CMD_WRITE_DATA, 8'h00, 16'h0000, 16'h7E7E);
        push_command(CMD_WRITE_MULTI, 8'hFF, 16'hFFFF, 16'(MAX_WORDS));
        push_command(CMD_WRITE_SINGLE, 8'h80, 16'h8000, 16'h0001);

        drain_frames();

        // The largest frame once, then mostly well-formed traffic with noise.
        push_command(CMD_WRITE_MULTI, any_octet(), any_word(), 16'(MAX_WORDS));
        push_data_words(MAX_WORDS);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - CALM_ITEMS)
            begin
                source_calm = 1'b1;
                sink_calm   = 1'b1;
            end
            choice = $urandom_range(0, 99);
            if (choice < 45)
            begin
                words = ($urandom_range(0, 59) == 0) ? MAX_WORDS : $urandom_range(1, 6);
                push_command(CMD_WRITE_MULTI, any_octet(), any_word(), 16'(words));
                push_data_words(words);
            end
            else if (choice < 75)
            begin
                push_command($urandom_range(0, 1) ? CMD_WRITE_SINGLE : CMD_READ_HOLDING,
                             any_octet(), any_word(), any_word());
            end
            else if (choice < 82)
            begin
                push_data_words(1);
            end
            else if (choice < 90)
            begin
                push_command(CMD_WRITE_MULTI, any_octet(), any_word(),
                             ($urandom_range(0, 3) == 0) ? 16'd0
                                 : 16'($urandom_range(MAX_WORDS + 1, 16'hFFFF)));
            end
            else if (choice < 96)
            begin
                // Broken sequence: header, too few words, maybe a bad count after them.
                words = $urandom_range(2, 6);
                sent  = $urandom_range(1, words - 1);
                push_command(CMD_WRITE_MULTI, any_octet(), any_word(), 16'(words));
                push_data_words(sent);
                if ($urandom_range(0, 1))
                    push_command(CMD_WRITE_MULTI, any_octet(), any_word(), 16'd0);
            end
            else
            begin
                push_command(cmd_t'($urandom_range(0, 3)), any_octet(), any_word(), any_word());
            end
            if (items_sent >= 250 && items_sent < 260)
                drain_frames();
        end

        s_tvalid <= 1'b0;
        while (beats_due != 0) @(negedge clk);
        repeat (16) @(negedge clk);

        $display("Ran %0d request items through the framer: %0d frames closed with CRC,",
                 items_sent, frames_closed);
        $display("%0d items rejected, with random gaps and stalls on both channels.",
                 rejects_seen);
        if (mismatches == 0)
            $display("[modbus_rtu_request_framer_top] OK");
        else
            $display("[modbus_rtu_request_framer_top] ERROR");
        $finish;
    end

endmodule
